FILE: rtl/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared constants, codes and types of the breadth-first traversal block.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  // graph size limits
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int STORE_DEPTH  = 2 * MAX_EDGES;

  // derived widths
  localparam int VTX_W = $clog2(MAX_VERTICES);     // vertex index
  localparam int QP_W  = $clog2(MAX_VERTICES + 1); // queue pointer, scan counter, count
  localparam int ENT_W = $clog2(STORE_DEPTH);      // list entry address
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);  // entries in use

  // request and result field widths
  localparam int OP_W  = 2;
  localparam int END_W = 6;
  localparam int CFG_W = 7;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_VERTEX_COUNT = 1'b0;   // word index of vertex_count
  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(64);

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK_A,
    S_CHK_B,
    S_REJECT,
    S_CLEAR,
    S_ARD_A,
    S_AWR_A,
    S_ARD_B,
    S_AWR_B,
    S_T_INIT,
    S_SCAN,
    S_DEQ,
    S_LOADQ,
    S_PUSH,
    S_FETCH,
    S_NBR,
    S_FINISH
  } state_t;

  // commands from the sequencer to the adjacency store
  typedef struct packed {
    logic             clr;        // empty every list
    logic             lst_re;     // read head, tail and nonempty of one vertex
    logic [VTX_W-1:0] lst_vtx;
    logic             app_we;     // append one entry, uses the last list read
    logic [VTX_W-1:0] app_owner;
    logic [VTX_W-1:0] app_nb;
    logic             ent_re;     // read one list entry
    logic [ENT_W-1:0] ent_addr;
  } adj_cmd_t;

  // answers of the adjacency store
  typedef struct packed {
    logic             nonempty;
    logic [ENT_W-1:0] head;
    logic [ENT_W-1:0] tail;
    logic [VTX_W-1:0] nb;
    logic [ENT_W-1:0] link;
    logic             full;
  } adj_rsp_t;

endpackage

FILE: rtl/gbfs_ram.sv
// ----------------------------------------------------------------------------
// gbfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbfs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/gbfs_adj.sv
// ----------------------------------------------------------------------------
// gbfs_adj
// Adjacency store: per-vertex linked neighbor lists in shared entry memories.
// ----------------------------------------------------------------------------
module gbfs_adj (
  input  logic               clk,
  input  logic               rst,
  input  gbfs_pkg::adj_cmd_t cmd,
  output gbfs_pkg::adj_rsp_t rsp
);

  logic [gbfs_pkg::MAX_VERTICES-1:0] vld;
  logic                              vld_q;
  logic [gbfs_pkg::CNT_W-1:0]        entry_count;
  logic [gbfs_pkg::ENT_W-1:0]        new_ent;
  logic [gbfs_pkg::ENT_W-1:0]        head_q;
  logic [gbfs_pkg::ENT_W-1:0]        tail_q;
  logic [gbfs_pkg::VTX_W-1:0]        nb_q;
  logic [gbfs_pkg::ENT_W-1:0]        link_q;

  // next free entry
  assign new_ent = entry_count[gbfs_pkg::ENT_W-1:0];

  // neighbor values of all entries
  gbfs_ram #(.DEPTH(gbfs_pkg::STORE_DEPTH), .WIDTH(gbfs_pkg::VTX_W)) u_nbr (
    .clk   (clk),
    .we    (cmd.app_we),
    .waddr (new_ent),
    .wdata (cmd.app_nb),
    .re    (cmd.ent_re),
    .raddr (cmd.ent_addr),
    .rdata (nb_q)
  );

  // link from the old tail to the new entry
  gbfs_ram #(.DEPTH(gbfs_pkg::STORE_DEPTH), .WIDTH(gbfs_pkg::ENT_W)) u_link (
    .clk   (clk),
    .we    (cmd.app_we && vld_q),
    .waddr (tail_q),
    .wdata (new_ent),
    .re    (cmd.ent_re),
    .raddr (cmd.ent_addr),
    .rdata (link_q)
  );

  // list heads, written on the first entry of a list
  gbfs_ram #(.DEPTH(gbfs_pkg::MAX_VERTICES), .WIDTH(gbfs_pkg::ENT_W)) u_head (
    .clk   (clk),
    .we    (cmd.app_we && !vld_q),
    .waddr (cmd.app_owner),
    .wdata (new_ent),
    .re    (cmd.lst_re),
    .raddr (cmd.lst_vtx),
    .rdata (head_q)
  );

  // list tails
  gbfs_ram #(.DEPTH(gbfs_pkg::MAX_VERTICES), .WIDTH(gbfs_pkg::ENT_W)) u_tail (
    .clk   (clk),
    .we    (cmd.app_we),
    .waddr (cmd.app_owner),
    .wdata (new_ent),
    .re    (cmd.lst_re),
    .raddr (cmd.lst_vtx),
    .rdata (tail_q)
  );

  // nonempty flags and entry count
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      vld         <= '0;
      vld_q       <= 1'b0;
      entry_count <= '0;
    end else begin
      if (cmd.lst_re) begin
        vld_q <= vld[cmd.lst_vtx];
      end
      if (cmd.app_we) begin
        vld[cmd.app_owner] <= 1'b1;
        entry_count        <= entry_count + gbfs_pkg::CNT_W'(1);
      end
    end
  end

  // answers
  always_comb begin
    rsp.nonempty = vld_q;
    rsp.head     = head_q;
    rsp.tail     = tail_q;
    rsp.nb       = nb_q;
    rsp.link     = link_q;
    rsp.full     = entry_count > gbfs_pkg::CNT_W'(gbfs_pkg::STORE_DEPTH - 2);
  end

endmodule

FILE: rtl/gbfs_seq.sv
// ----------------------------------------------------------------------------
// gbfs_seq
// Sequencer: edge checks and appends, list clears, breadth-first walk, result register.
// ----------------------------------------------------------------------------
module gbfs_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gbfs_pkg::OP_W-1:0]   operation,
  input  logic [gbfs_pkg::END_W-1:0]  end_a,
  input  logic [gbfs_pkg::END_W-1:0]  end_b,
  input  logic [gbfs_pkg::QP_W-1:0]   cnt,
  output gbfs_pkg::adj_cmd_t          adj_cmd,
  input  gbfs_pkg::adj_rsp_t          adj_rsp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbfs_pkg::END_W-1:0]  vertex,
  output logic                        last,
  output logic                        rejected
);

  gbfs_pkg::state_t state, state_next;

  logic [gbfs_pkg::VTX_W-1:0]        a_q, b_q;
  logic [gbfs_pkg::QP_W-1:0]         s, qh, qt;
  logic [gbfs_pkg::VTX_W-1:0]        cur, held_vtx;
  logic                              held_valid;
  logic [gbfs_pkg::ENT_W-1:0]        e, tail_r;
  logic [gbfs_pkg::MAX_VERTICES-1:0] visited;

  logic [gbfs_pkg::QP_W-1:0]  cmp_opnd;
  logic                       cmp_lt;
  logic                       slot_free;
  logic                       q_empty;
  logic                       mark_s, mark_nb, enq;
  logic                       q_re;
  logic [gbfs_pkg::VTX_W-1:0] q_wdata, q_rdata;
  logic                       push, push_last, push_rej;
  logic [gbfs_pkg::VTX_W-1:0] push_vtx;
  logic                       take_cur;

  // shared range comparator against the vertex count
  assign cmp_lt    = cmp_opnd < cnt;
  assign slot_free = !out_valid || out_ready;
  assign q_empty   = qh == qt;

  // visit queue
  gbfs_ram #(.DEPTH(gbfs_pkg::MAX_VERTICES), .WIDTH(gbfs_pkg::VTX_W)) u_queue (
    .clk   (clk),
    .we    (enq),
    .waddr (qt[gbfs_pkg::VTX_W-1:0]),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (qh[gbfs_pkg::VTX_W-1:0]),
    .rdata (q_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gbfs_pkg::S_IDLE: begin
        if (in_valid) begin
          case (operation)
            gbfs_pkg::OP_ADD:      state_next = gbfs_pkg::S_CHK_A;
            gbfs_pkg::OP_TRAVERSE: state_next = gbfs_pkg::S_T_INIT;
            gbfs_pkg::OP_CLEAR:    state_next = gbfs_pkg::S_CLEAR;
            default:               state_next = gbfs_pkg::S_IDLE;
          endcase
        end
      end
      gbfs_pkg::S_CHK_A: begin
        state_next = (!cmp_lt || adj_rsp.full) ? gbfs_pkg::S_REJECT : gbfs_pkg::S_CHK_B;
      end
      gbfs_pkg::S_CHK_B: begin
        state_next = cmp_lt ? gbfs_pkg::S_ARD_A : gbfs_pkg::S_REJECT;
      end
      gbfs_pkg::S_REJECT: begin
        if (slot_free) begin
          state_next = gbfs_pkg::S_IDLE;
        end
      end
      gbfs_pkg::S_CLEAR:  state_next = gbfs_pkg::S_IDLE;
      gbfs_pkg::S_ARD_A:  state_next = gbfs_pkg::S_AWR_A;
      gbfs_pkg::S_AWR_A:  state_next = gbfs_pkg::S_ARD_B;
      gbfs_pkg::S_ARD_B:  state_next = gbfs_pkg::S_AWR_B;
      gbfs_pkg::S_AWR_B:  state_next = gbfs_pkg::S_IDLE;
      gbfs_pkg::S_T_INIT: state_next = gbfs_pkg::S_SCAN;
      gbfs_pkg::S_SCAN: begin
        if (!cmp_lt) begin
          state_next = gbfs_pkg::S_FINISH;
        end else if (!visited[s[gbfs_pkg::VTX_W-1:0]]) begin
          state_next = gbfs_pkg::S_DEQ;
        end
      end
      gbfs_pkg::S_DEQ: begin
        state_next = q_empty ? gbfs_pkg::S_SCAN : gbfs_pkg::S_LOADQ;
      end
      gbfs_pkg::S_LOADQ:  state_next = gbfs_pkg::S_PUSH;
      gbfs_pkg::S_PUSH: begin
        if (take_cur) begin
          state_next = adj_rsp.nonempty ? gbfs_pkg::S_FETCH : gbfs_pkg::S_DEQ;
        end
      end
      gbfs_pkg::S_FETCH:  state_next = gbfs_pkg::S_NBR;
      gbfs_pkg::S_NBR: begin
        state_next = (e == tail_r) ? gbfs_pkg::S_DEQ : gbfs_pkg::S_FETCH;
      end
      gbfs_pkg::S_FINISH: begin
        if (!held_valid || slot_free) begin
          state_next = gbfs_pkg::S_IDLE;
        end
      end
      default: state_next = gbfs_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    cmp_opnd  = '0;
    mark_s    = 1'b0;
    mark_nb   = 1'b0;
    q_re      = 1'b0;
    q_wdata   = adj_rsp.nb;
    push      = 1'b0;
    push_last = 1'b0;
    push_rej  = 1'b0;
    push_vtx  = held_vtx;
    take_cur  = 1'b0;
    adj_cmd   = '0;
    case (state)
      gbfs_pkg::S_IDLE:  in_ready = 1'b1;
      gbfs_pkg::S_CHK_A: cmp_opnd = gbfs_pkg::QP_W'(a_q);
      gbfs_pkg::S_CHK_B: cmp_opnd = gbfs_pkg::QP_W'(b_q);
      gbfs_pkg::S_REJECT: begin
        push     = slot_free;
        push_rej = 1'b1;
        push_vtx = '0;
      end
      gbfs_pkg::S_CLEAR: adj_cmd.clr = 1'b1;
      gbfs_pkg::S_ARD_A: begin
        adj_cmd.lst_re  = 1'b1;
        adj_cmd.lst_vtx = a_q;
      end
      gbfs_pkg::S_AWR_A: begin
        adj_cmd.app_we    = 1'b1;
        adj_cmd.app_owner = a_q;
        adj_cmd.app_nb    = b_q;
      end
      gbfs_pkg::S_ARD_B: begin
        adj_cmd.lst_re  = 1'b1;
        adj_cmd.lst_vtx = b_q;
      end
      gbfs_pkg::S_AWR_B: begin
        adj_cmd.app_we    = 1'b1;
        adj_cmd.app_owner = b_q;
        adj_cmd.app_nb    = a_q;
      end
      gbfs_pkg::S_SCAN: begin
        cmp_opnd = s;
        mark_s   = cmp_lt && !visited[s[gbfs_pkg::VTX_W-1:0]];
        q_wdata  = s[gbfs_pkg::VTX_W-1:0];
      end
      gbfs_pkg::S_DEQ:   q_re = !q_empty;
      gbfs_pkg::S_LOADQ: begin
        adj_cmd.lst_re  = 1'b1;
        adj_cmd.lst_vtx = q_rdata;
      end
      gbfs_pkg::S_PUSH: begin
        take_cur = !held_valid || slot_free;
        push     = held_valid && slot_free;
      end
      gbfs_pkg::S_FETCH: begin
        adj_cmd.ent_re   = 1'b1;
        adj_cmd.ent_addr = e;
      end
      gbfs_pkg::S_NBR: begin
        cmp_opnd = gbfs_pkg::QP_W'(adj_rsp.nb);
        mark_nb  = cmp_lt && !visited[adj_rsp.nb];
      end
      gbfs_pkg::S_FINISH: begin
        push      = held_valid && slot_free;
        push_last = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign enq = mark_s || mark_nb;

  // state, queue pointers and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbfs_pkg::S_IDLE;
      qh         <= '0;
      qt         <= '0;
      held_valid <= 1'b0;
      visited    <= '0;
    end else begin
      state <= state_next;
      if (state == gbfs_pkg::S_T_INIT) begin
        qh         <= '0;
        qt         <= '0;
        held_valid <= 1'b0;
        visited    <= '0;
      end
      if (enq) begin
        qt               <= qt + gbfs_pkg::QP_W'(1);
        visited[q_wdata] <= 1'b1;
      end
      if (q_re) begin
        qh <= qh + gbfs_pkg::QP_W'(1);
      end
      if (take_cur) begin
        held_valid <= 1'b1;
      end
      if (state == gbfs_pkg::S_FINISH && state_next == gbfs_pkg::S_IDLE) begin
        held_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_q <= gbfs_pkg::VTX_W'(end_a);
      b_q <= gbfs_pkg::VTX_W'(end_b);
    end
    if (state == gbfs_pkg::S_T_INIT) begin
      s <= '0;
    end else if (state == gbfs_pkg::S_SCAN && cmp_lt) begin
      s <= s + gbfs_pkg::QP_W'(1);
    end
    if (state == gbfs_pkg::S_LOADQ) begin
      cur <= q_rdata;
    end
    if (take_cur) begin
      held_vtx <= cur;
      e        <= adj_rsp.head;
      tail_r   <= adj_rsp.tail;
    end else if (state == gbfs_pkg::S_NBR) begin
      e <= adj_rsp.link;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      vertex   <= gbfs_pkg::END_W'(push_vtx);
      last     <= push_last;
      rejected <= push_rej;
    end
  end

endmodule

FILE: rtl/graph_bfs_traversal_order.sv
// Edge add: both ends are range-checked, then each end's list is read and appended
// to in turn. Rejected edge: a failed check, then a wait for the output slot. Clear:
// empties every list. Traversal: the single sequencer reads one list entry at a time and waits on output stalls.
// One request is in work at a time; results leave through a one-entry output register.
// Reset (rst, synchronous, active high): all lists empty, vertex_count = 64, no
// clearing pass over the memories.
// ----------------------------------------------------------------------------
// graph_bfs_traversal_order
// Undirected graph store with breadth-first traversal over all components.
// ----------------------------------------------------------------------------
module graph_bfs_traversal_order (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gbfs_pkg::OP_W-1:0]    operation,
  input  logic [gbfs_pkg::END_W-1:0]   end_a,
  input  logic [gbfs_pkg::END_W-1:0]   end_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gbfs_pkg::END_W-1:0]   vertex,
  output logic                         last,
  output logic                         rejected,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbfs_pkg::ADDR_W-1:0]  paddr,
  input  logic [gbfs_pkg::DATA_W-1:0]  pwdata,
  output logic [gbfs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [gbfs_pkg::CFG_W-1:0] vertex_count;
  logic [gbfs_pkg::QP_W-1:0]  cnt;
  gbfs_pkg::adj_cmd_t         adj_cmd;
  gbfs_pkg::adj_rsp_t         adj_rsp;
  logic                       reg_sel;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == gbfs_pkg::REG_VERTEX_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gbfs_pkg::VERTEX_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vertex_count <= pwdata[gbfs_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? gbfs_pkg::DATA_W'(vertex_count) : '0;

  // effective vertex count, capped at MAX_VERTICES
  always_comb begin
    if (32'(vertex_count) > gbfs_pkg::MAX_VERTICES) begin
      cnt = gbfs_pkg::QP_W'(gbfs_pkg::MAX_VERTICES);
    end else begin
      cnt = gbfs_pkg::QP_W'(vertex_count);
    end
  end

  // adjacency lists
  gbfs_adj u_adj (
    .clk (clk),
    .rst (rst),
    .cmd (adj_cmd),
    .rsp (adj_rsp)
  );

  // sequencer
  gbfs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .end_a     (end_a),
    .end_b     (end_b),
    .cnt       (cnt),
    .adj_cmd   (adj_cmd),
    .adj_rsp   (adj_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vertex    (vertex),
    .last      (last),
    .rejected  (rejected)
  );

`ifndef ASSERT_OFF
  // an append always follows the read of its owner's tail
  a_append_after_read: assert property (@(posedge clk) disable iff (rst)
    adj_cmd.app_we |-> $past(adj_cmd.lst_re))
    else $error("append without preceding list read");

  // no store activity while waiting for a request
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!adj_cmd.ent_re && !adj_cmd.app_we))
    else $error("store access while idle");

  // a reject result never closes a traversal
  a_reject_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rejected && last))
    else $error("reject result flagged as last");
`endif

endmodule

FILE: tb/sv/graph_bfs_traversal_order_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_bfs_traversal_order_tb
// Loads edges, changes the vertex count over the config port and runs
// breadth-first traversals. Every result is checked against an in-bench
// model of the adjacency lists or the output a typed plan row expects.
// A directed walk comes first, then a fill of the whole edge store, then
// random graph sessions. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module graph_bfs_traversal_order_tb;

  localparam int unsigned NO_LINK       = 32'hFFFF_FFFF;
  localparam int unsigned ITEM_GOAL     = 410;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam logic [gbfs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int REG_SPARE = 1;  // address past the register list

  typedef struct packed {
    logic [gbfs_pkg::END_W-1:0] vertex;
    logic                       last;
    logic                       rejected;
  } gbfs_out_t;

  typedef struct {
    bit                         is_cfg;
    int                         reg_idx;
    int unsigned                cfg_value;
    logic [gbfs_pkg::OP_W-1:0]  op;
    logic [gbfs_pkg::END_W-1:0] a;
    logic [gbfs_pkg::END_W-1:0] b;
    bit                         typed;
    gbfs_out_t                  want;
  } plan_row_t;

  typedef enum {PACE_OPEN, PACE_COIN, PACE_PATTERN, PACE_HOLD} pace_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [gbfs_pkg::OP_W-1:0]     operation = '0;
  logic [gbfs_pkg::END_W-1:0]    end_a = '0;
  logic [gbfs_pkg::END_W-1:0]    end_b = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [gbfs_pkg::END_W-1:0]    vertex;
  logic                          last;
  logic                          rejected;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [gbfs_pkg::ADDR_W-1:0]   paddr = '0;
  logic [gbfs_pkg::DATA_W-1:0]   pwdata = '0;
  logic [gbfs_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // adjacency model
  logic [gbfs_pkg::VTX_W-1:0]    nbr_mem [gbfs_pkg::STORE_DEPTH];
  int unsigned                   link_mem [gbfs_pkg::STORE_DEPTH];
  int unsigned                   head_ptr [gbfs_pkg::MAX_VERTICES];
  int unsigned                   tail_ptr [gbfs_pkg::MAX_VERTICES];
  int unsigned                   used_entries;
  logic [gbfs_pkg::CFG_W-1:0]    vcount_reg;

  gbfs_out_t          step_outputs[$];
  gbfs_out_t          due_outputs[$];
  plan_row_t          plan[$];

  int unsigned        fail_count = 0;
  int unsigned        outputs_checked = 0;
  int unsigned        requests_sent = 0;
  int unsigned        traversals = 0;
  int unsigned        edges_dropped = 0;
  int unsigned        cycle_count = 0;
  int unsigned        burst_left = 0;
  bit                 steady_send = 1'b0;

  pace_t              pace_mode = PACE_OPEN;
  int unsigned        pace_left = 0;
  int unsigned        hold_left = 0;
  logic [7:0]         pace_bits = 8'h01;

  graph_bfs_traversal_order dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .end_a     (end_a),
    .end_b     (end_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vertex    (vertex),
    .last      (last),
    .rejected  (rejected),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned eff_span();
    return (vcount_reg > gbfs_pkg::MAX_VERTICES) ? gbfs_pkg::MAX_VERTICES : vcount_reg;
  endfunction

  function automatic void wipe_lists();
    for (int v = 0; v < gbfs_pkg::MAX_VERTICES; v++) begin
      head_ptr[v] = NO_LINK;
      tail_ptr[v] = NO_LINK;
    end
    used_entries = 0;
  endfunction

  // append one neighbor to the tail of an owner's list
  function automatic void link_entry(input logic [gbfs_pkg::VTX_W-1:0] owner,
                                     input logic [gbfs_pkg::VTX_W-1:0] nb);
    int unsigned slot;
    slot = used_entries;
    nbr_mem[slot] = nb;
    link_mem[slot] = NO_LINK;
    if (tail_ptr[owner] < gbfs_pkg::STORE_DEPTH) begin
      link_mem[tail_ptr[owner]] = slot;
    end else begin
      head_ptr[owner] = slot;
    end
    tail_ptr[owner] = slot;
    used_entries = slot + 1;
  endfunction

  // update the graph for one request and collect the outputs it causes
  function automatic void apply_graph_request(input logic [gbfs_pkg::OP_W-1:0] op,
                                              input logic [gbfs_pkg::END_W-1:0] a,
                                              input logic [gbfs_pkg::END_W-1:0] b);
    int unsigned                span;
    int unsigned                qh;
    int unsigned                qt;
    int unsigned                e;
    int unsigned                s;
    logic [gbfs_pkg::VTX_W-1:0] cur;
    logic [gbfs_pkg::VTX_W-1:0] nb;
    bit                         seen [gbfs_pkg::MAX_VERTICES];
    logic [gbfs_pkg::VTX_W-1:0] frontier [gbfs_pkg::MAX_VERTICES];
    gbfs_out_t                  o;
    step_outputs.delete();
    span = eff_span();
    case (op)
      gbfs_pkg::OP_ADD: begin
        if (a >= span || b >= span || used_entries + 2 > gbfs_pkg::STORE_DEPTH) begin
          o = '0;
          o.rejected = 1'b1;
          step_outputs.insert(step_outputs.size(), o);
          edges_dropped++;
        end else begin
          link_entry(a, b);
          link_entry(b, a);
        end
      end
      gbfs_pkg::OP_TRAVERSE: begin
        seen = '{default: 1'b0};
        for (s = 0; s < span; s++) begin
          if (seen[s]) continue;
          seen[s] = 1'b1;
          frontier[0] = gbfs_pkg::VTX_W'(s);
          qh = 0;
          qt = 1;
          while (qh < qt) begin
            cur = frontier[qh];
            qh++;
            o = '0;
            o.vertex = cur;
            step_outputs.insert(step_outputs.size(), o);
            // neighbors in list order, entries past the count are skipped
            e = head_ptr[cur];
            while (e < used_entries) begin
              nb = nbr_mem[e];
              if (nb < span && !seen[nb] && qt < gbfs_pkg::MAX_VERTICES) begin
                seen[nb] = 1'b1;
                frontier[qt] = nb;
                qt++;
              end
              e = link_mem[e];
            end
          end
        end
        if (step_outputs.size() > 0) begin
          o = step_outputs.pop_back();
          o.last = 1'b1;
          step_outputs.insert(step_outputs.size(), o);
        end
      end
      gbfs_pkg::OP_CLEAR: wipe_lists();
      default: ;
    endcase
  endfunction

  function automatic logic [gbfs_pkg::END_W-1:0] pick_end(input bit in_range);
    int unsigned span;
    span = eff_span();
    if (in_range && span > 0) return gbfs_pkg::END_W'($urandom_range(0, span - 1));
    return gbfs_pkg::END_W'($urandom);
  endfunction

  // ------------------------------------------------------------- plan rows

  function automatic plan_row_t row_req(input logic [gbfs_pkg::OP_W-1:0] op,
                                        input logic [gbfs_pkg::END_W-1:0] a,
                                        input logic [gbfs_pkg::END_W-1:0] b);
    plan_row_t r;
    r = '{default: '0};
    r.op = op;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic plan_row_t row_typed(input logic [gbfs_pkg::OP_W-1:0] op,
                                          input logic [gbfs_pkg::END_W-1:0] a,
                                          input logic [gbfs_pkg::END_W-1:0] b,
                                          input logic [gbfs_pkg::END_W-1:0] v,
                                          input logic l,
                                          input logic rj);
    plan_row_t r;
    r = row_req(op, a, b);
    r.typed = 1'b1;
    r.want.vertex = v;
    r.want.last = l;
    r.want.rejected = rj;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(input int idx, input int unsigned value);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.cfg_value = value;
    return r;
  endfunction

  // put one row at the end of the table
  function automatic void add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // ---------------------------------------------------------------- driving

  // send one request with burst/gap pacing, then predict its outputs
  task automatic issue(input logic [gbfs_pkg::OP_W-1:0] op,
                       input logic [gbfs_pkg::END_W-1:0] a,
                       input logic [gbfs_pkg::END_W-1:0] b, input bit typed,
                       input gbfs_out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_send ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    operation <= op;
    end_a     <= a;
    end_b     <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    apply_graph_request(op, a, b);
    if (typed) due_outputs.insert(due_outputs.size(), want);
    else foreach (step_outputs[i]) due_outputs.insert(due_outputs.size(), step_outputs[i]);
    if (op == gbfs_pkg::OP_TRAVERSE) traversals++;
    if (op != OP_UNUSED) requests_sent++;
  endtask

  // hold off new requests until every predicted output has come back
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // read vertex_count back; ends with the bus idle
  task automatic cfg_readback();
    logic [gbfs_pkg::DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= gbfs_pkg::ADDR_W'(4 * gbfs_pkg::REG_VERTEX_COUNT);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[gbfs_pkg::CFG_W-1:0] !== vcount_reg) begin
      $error("vertex_count: expected %0d, got %0d", vcount_reg,
             got[gbfs_pkg::CFG_W-1:0]);
      fail_count++;
    end
  endtask

  // register write while idle, followed by a read back
  task automatic set_register(input int idx, input int unsigned value);
    drain_outputs();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gbfs_pkg::ADDR_W'(4 * idx);
    pwdata  <= gbfs_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == gbfs_pkg::REG_VERTEX_COUNT) vcount_reg = value[gbfs_pkg::CFG_W-1:0];
    cfg_readback();
  endtask

  // ------------------------------------------------------------ result side

  // receiver stalls in randomly chosen pacing modes
  always @(posedge clk) begin : out_pacing
    logic ready_next;
    if (pace_left == 0) begin
      pace_mode = pace_t'($urandom_range(0, 3));
      pace_left = $urandom_range(20, 120);
      pace_bits = 8'($urandom) | 8'h01;
      hold_left = 0;
    end else begin
      pace_left--;
    end
    ready_next = out_ready;
    case (pace_mode)
      PACE_OPEN: ready_next = 1'b1;
      PACE_COIN: ready_next = ($urandom_range(0, 1) == 1);
      PACE_PATTERN: begin
        ready_next = pace_bits[0];
        pace_bits = {pace_bits[0], pace_bits[7:1]};
      end
      default: begin
        if (hold_left == 0) begin
          ready_next = !out_ready;
          hold_left = out_ready ? $urandom_range(4, 12) : $urandom_range(1, 3);
        end else begin
          hold_left--;
        end
      end
    endcase
    out_ready <= ready_next;
  end

  // compare each accepted output with the oldest prediction
  always @(posedge clk) begin : out_check
    gbfs_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_outputs.size() == 0) begin
        $error("unexpected output: vertex %0d last %0d rejected %0d",
               vertex, last, rejected);
        fail_count++;
      end else begin
        want = due_outputs.pop_front();
        outputs_checked++;
        if (vertex !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, vertex);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
        if (rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, rejected);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : main
    int unsigned new_count;
    int unsigned adds;
    wipe_lists();
    vcount_reg = gbfs_pkg::VERTEX_COUNT_RESET;

    // directed walk
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));     // empty graph, all singletons
    add_row(row_req(gbfs_pkg::OP_ADD, 63, 0));
    add_row(row_req(gbfs_pkg::OP_ADD, 0, 63));
    add_row(row_req(gbfs_pkg::OP_ADD, 5, 5));          // self loop
    add_row(row_req(gbfs_pkg::OP_ADD, 1, 2));
    add_row(row_req(gbfs_pkg::OP_ADD, 2, 3));
    add_row(row_req(gbfs_pkg::OP_ADD, 0, 1));
    add_row(row_req(OP_UNUSED, 63, 63));               // ignored operation
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));
    add_row(row_cfg(gbfs_pkg::REG_VERTEX_COUNT, 10));  // count lowered after loading
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));
    add_row(row_typed(gbfs_pkg::OP_ADD, 10, 3, 0, 1'b0, 1'b1));
    add_row(row_typed(gbfs_pkg::OP_ADD, 3, 63, 0, 1'b0, 1'b1));
    add_row(row_req(gbfs_pkg::OP_ADD, 9, 9));
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));
    add_row(row_cfg(gbfs_pkg::REG_VERTEX_COUNT, 1));
    add_row(row_typed(gbfs_pkg::OP_TRAVERSE, 0, 0, 0, 1'b1, 1'b0));
    add_row(row_req(gbfs_pkg::OP_ADD, 0, 0));
    add_row(row_typed(gbfs_pkg::OP_ADD, 0, 1, 0, 1'b0, 1'b1));
    add_row(row_typed(gbfs_pkg::OP_TRAVERSE, 0, 0, 0, 1'b1, 1'b0));
    add_row(row_cfg(gbfs_pkg::REG_VERTEX_COUNT, 0));   // zero count
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));
    add_row(row_typed(gbfs_pkg::OP_ADD, 0, 0, 0, 1'b0, 1'b1));
    add_row(row_cfg(REG_SPARE, 5));                    // write past the list, no effect
    add_row(row_cfg(gbfs_pkg::REG_VERTEX_COUNT, 127)); // clamps to the vertex limit
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));
    add_row(row_req(gbfs_pkg::OP_CLEAR, 63, 63));
    add_row(row_req(gbfs_pkg::OP_TRAVERSE, 0, 0));

    // reset
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    cfg_readback();

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_register(plan[i].reg_idx, plan[i].cfg_value);
      end else begin
        issue(plan[i].op, plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // fill the edge store to the top, then overflow it
    set_register(gbfs_pkg::REG_VERTEX_COUNT, gbfs_pkg::MAX_VERTICES);
    issue(gbfs_pkg::OP_CLEAR, pick_end(0), pick_end(0), 1'b0, '0);
    while (used_entries + 2 <= gbfs_pkg::STORE_DEPTH) begin
      issue(gbfs_pkg::OP_ADD, pick_end(1), pick_end(1), 1'b0, '0);
      if (used_entries % 128 == 0) begin
        issue(gbfs_pkg::OP_TRAVERSE, pick_end(0), pick_end(0), 1'b0, '0);
      end
    end
    repeat (3) issue(gbfs_pkg::OP_ADD, pick_end(0), pick_end(0), 1'b0, '0);
    issue(gbfs_pkg::OP_TRAVERSE, pick_end(0), pick_end(0), 1'b0, '0);
    set_register(gbfs_pkg::REG_VERTEX_COUNT, $urandom_range(2, 20));
    issue(gbfs_pkg::OP_TRAVERSE, pick_end(0), pick_end(0), 1'b0, '0);

    // random graph sessions
    while (requests_sent < ITEM_GOAL) begin
      steady_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: new_count = 0;
          1: new_count = 1;
          2: new_count = 2;
          3: new_count = 64;
          4: new_count = 127;
          5: new_count = $urandom_range(33, 63);
          default: new_count = $urandom_range(3, 16);
        endcase
        set_register(gbfs_pkg::REG_VERTEX_COUNT, new_count);
      end
      if ($urandom_range(0, 3) != 0) begin
        issue(gbfs_pkg::OP_CLEAR, pick_end(0), pick_end(0), 1'b0, '0);
      end
      adds = $urandom_range(1, 14);
      repeat (adds) begin
        case ($urandom_range(0, 19))
          0: issue(OP_UNUSED, pick_end(0), pick_end(0), 1'b0, '0);
          1: issue(gbfs_pkg::OP_CLEAR, pick_end(0), pick_end(0), 1'b0, '0);
          2, 3: issue(gbfs_pkg::OP_ADD, pick_end(0), pick_end(0), 1'b0, '0);
          4: issue(gbfs_pkg::OP_TRAVERSE, pick_end(0), pick_end(0), 1'b0, '0);
          default: issue(gbfs_pkg::OP_ADD, pick_end(1), pick_end(1), 1'b0, '0);
        endcase
      end
      issue(gbfs_pkg::OP_TRAVERSE, pick_end(0), pick_end(0), 1'b0, '0);
    end

    // wind down and report
    drain_outputs();
    if (due_outputs.size() != 0) begin
      $error("%0d predicted outputs never arrived", due_outputs.size());
      fail_count++;
    end
    $display("run covered %0d requests, %0d traversals and %0d dropped edges",
             requests_sent, traversals, edges_dropped);
    $display("%0d outputs compared, %0d failures", outputs_checked, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
